>>> rtl/hbd_pkg.sv
// Package for the hash bucket dispatcher: sizes, result kinds, hash constants.
// Used by hash_bucket_dispatcher; depends on nothing.
`timescale 1ns / 1ps
package hbd_pkg;
  localparam int NUM_BUCKETS = 4;
  localparam int BUCKET_BITS = 2;
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int BCNT_W = $clog2(NUM_BUCKETS + 1);
  localparam int STORE_DEPTH = NUM_BUCKETS * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ENTRY_W = 96;

  localparam logic [1:0] KIND_RECEIPT = 2'd0;
  localparam logic [1:0] KIND_ENTRY   = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  localparam logic [63:0] C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] F2 = 64'hc4ceb9fe1a85ec53;

  typedef logic [63:0] word_t;
endpackage

>>> rtl/hbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; depends on nothing.
`timescale 1ns / 1ps
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/hash_bucket_dispatcher.sv
// Hash bucket dispatcher: the first word of MurmurHash3 x64_128 over a 32-bit key picks one
// of NUM_BUCKETS FIFOs. One shared 32x32 multiplier builds each 64-bit multiply from three
// partial products plus a step state; six multiplies make the receipt. A new arrive
// request is taken only after the last receipt is accepted. A drain skips empty buckets,
// pops the head entry of each other bucket, or gives one empty result if all are empty;
// receiver stalls hold both. Synchronous reset clears state, seed, valid, last and pointers.
`timescale 1ns / 1ps
module hash_bucket_dispatcher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata: [31:0] key, [63:32] payload_handle
  input  logic [63:0]  in_tdata,
  // in_tuser: [0] mode
  input  logic         in_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: [1:0] bucket, [65:2] hash, [97:66] out_handle,
  // [98] dropped, [103:99] zero fill
  output logic [103:0] out_tdata,
  // out_tuser: [1:0] result_kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;  // accumulate partial products
  localparam logic [3:0] S_STEP  = 4'd2;  // pick next operation of the hash
  localparam logic [3:0] S_PUSH  = 4'd3;
  localparam logic [3:0] S_DSCAN = 4'd4;
  localparam logic [3:0] S_DREAD = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;

  logic [3:0] state_r, state_nxt;
  logic [31:0] seed_r;

  // Hash working registers.
  hbd_pkg::word_t h1_r, h2_r, acc_r, opa_r, opb_r;
  logic [1:0] pp_r;      // partial product index
  logic [3:0] op_r;      // which hash operation is running
  logic [31:0] handle_r;
  logic        mode_r;

  // Bucket bookkeeping.
  logic [hbd_pkg::QPTR_W-1:0] head_r [hbd_pkg::NUM_BUCKETS];
  logic [hbd_pkg::QPTR_W-1:0] tail_r [hbd_pkg::NUM_BUCKETS];
  logic [hbd_pkg::OCC_W-1:0]  occ_r  [hbd_pkg::NUM_BUCKETS];
  logic [hbd_pkg::BCNT_W-1:0] scan_r;
  logic                       found_r;

  // Output register.
  logic         ov_r;
  logic [1:0]   okind_r, obkt_r;
  logic [63:0]  ohash_r;
  logic [31:0]  ohandle_r;
  logic         odrop_r, olast_r;

  // RAM.
  logic                        ram_we;
  logic [hbd_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [hbd_pkg::ENTRY_W-1:0] ram_rdata;

  hbd_ram #(.WIDTH(hbd_pkg::ENTRY_W), .DEPTH(hbd_pkg::STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata({handle_r, h1_r}),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // One 32x32 partial product per cycle; pp_r selects the halves and shift.
  logic [31:0] mul_a, mul_b;
  logic [63:0] pprod, pp_shift;
  always_comb begin
    mul_a = pp_r[0] ? opa_r[63:32] : opa_r[31:0];
    mul_b = pp_r[1] ? opb_r[63:32] : opb_r[31:0];
    pprod = 64'(mul_a) * 64'(mul_b);
    unique case (pp_r)
      2'd0:    pp_shift = pprod;
      2'd3:    pp_shift = 64'd0;  // lands above bit 63
      default: pp_shift = {pprod[31:0], 32'd0};
    endcase
  end

  // Bucket of the finished hash and its FIFO status.
  logic [hbd_pkg::BUCKET_BITS-1:0] hb;
  logic [hbd_pkg::BIDX_W-1:0]      hbi;
  logic                            can_push;
  logic [hbd_pkg::BIDX_W-1:0]      sbi;
  logic                            later_busy;
  hbd_pkg::word_t                  mix_h1;
  always_comb begin
    hb = h1_r[63 -: hbd_pkg::BUCKET_BITS];
    hbi = hbd_pkg::BIDX_W'(hb);
    can_push = (32'(hb) < 32'(hbd_pkg::NUM_BUCKETS)) &&
               (32'(occ_r[hbi]) < 32'(hbd_pkg::QUEUE_DEPTH));
    sbi = hbd_pkg::BIDX_W'(scan_r);
    ram_we = (state_r == S_PUSH) && can_push;
    ram_waddr = hbd_pkg::ADDR_W'(32'(hbi) * hbd_pkg::QUEUE_DEPTH + 32'(tail_r[hbi]));
    ram_raddr = hbd_pkg::ADDR_W'(32'(sbi) * hbd_pkg::QUEUE_DEPTH + 32'(head_r[sbi]));
    // A bucket after the one being drained still holds an entry.
    later_busy = 1'b0;
    for (int i = 0; i < hbd_pkg::NUM_BUCKETS; i++) begin
      if (32'(i) > 32'(scan_r) && occ_r[i] != '0) later_busy = 1'b1;
    end
    // h1 = seed ^ k1 ^ 4 plus h2 = seed ^ 4, with k1 finished in acc_r.
    mix_h1 = ({32'd0, seed_r} ^ acc_r ^ 64'd4) + {32'd0, seed_r ^ 32'd4};
  end

  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, odrop_r, ohandle_r, ohash_r, obkt_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  // Hash op sequence (op_r names the multiply just finished): 0 k*C1, 1 k*C2, then
  // combine, 2 f1 of h1, 3 f2 of h1, 4 f1 of h2, 5 f2 of h2; each fmix multiply is
  // preceded by a xorshift.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  state_nxt = (in_tvalid && in_tready) ?
                           (in_tuser ? S_DSCAN : S_MUL) : S_IDLE;
      S_MUL:   state_nxt = (pp_r == 2'd2) ? S_STEP : S_MUL;
      S_STEP:  state_nxt = (op_r == 4'd5) ? S_PUSH : S_MUL;
      S_PUSH:  state_nxt = S_OUT;
      S_DSCAN: begin
        if (32'(scan_r) >= 32'(hbd_pkg::NUM_BUCKETS)) state_nxt = S_OUT;
        else if (occ_r[sbi] != '0) state_nxt = S_DREAD;
        else state_nxt = S_DSCAN;
      end
      S_DREAD: state_nxt = S_OUT;
      S_OUT:   state_nxt = (!ov_r) ? ((mode_r && !olast_r) ? S_DSCAN : S_IDLE) : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seed_r  <= '0;
      ov_r    <= 1'b0;
      olast_r <= 1'b0;
      for (int i = 0; i < hbd_pkg::NUM_BUCKETS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) seed_r <= cfg_data;
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r   <= in_tuser;
            handle_r <= in_tdata[63:32];
            opa_r    <= {32'd0, in_tdata[31:0]};
            opb_r    <= hbd_pkg::C1;
            acc_r    <= '0;
            pp_r     <= 2'd0;
            op_r     <= 4'd0;
            scan_r   <= '0;
            found_r  <= 1'b0;
          end
        end
        S_MUL: begin
          acc_r <= acc_r + pp_shift;
          pp_r  <= pp_r + 2'd1;
        end
        S_STEP: begin
          pp_r  <= 2'd0;
          acc_r <= '0;
          op_r  <= op_r + 4'd1;
          unique case (op_r)
            4'd0: begin
              opa_r <= {acc_r[32:0], acc_r[63:33]};
              opb_r <= hbd_pkg::C2;
            end
            4'd1: begin
              // h1 += h2; h2 += h1; then fmix of h1 starts right away.
              h1_r  <= mix_h1;
              h2_r  <= mix_h1 + {32'd0, seed_r ^ 32'd4};
              opa_r <= mix_h1 ^ (mix_h1 >> 33);
              opb_r <= hbd_pkg::F1;
            end
            4'd2: begin
              opa_r <= acc_r ^ (acc_r >> 33);
              opb_r <= hbd_pkg::F2;
            end
            4'd3: begin
              h1_r  <= acc_r ^ (acc_r >> 33);
              opa_r <= h2_r ^ (h2_r >> 33);
              opb_r <= hbd_pkg::F1;
            end
            4'd4: begin
              opa_r <= acc_r ^ (acc_r >> 33);
              opb_r <= hbd_pkg::F2;
            end
            4'd5: begin
              h1_r <= h1_r + (acc_r ^ (acc_r >> 33));
            end
            default: ;
          endcase
        end
        S_PUSH: begin
          if (can_push) begin
            tail_r[hbi] <= tail_r[hbi] + hbd_pkg::QPTR_W'(1);
            occ_r[hbi]  <= occ_r[hbi] + hbd_pkg::OCC_W'(1);
          end
          ov_r      <= 1'b1;
          okind_r   <= hbd_pkg::KIND_RECEIPT;
          obkt_r    <= 2'(hb);
          ohash_r   <= h1_r;
          ohandle_r <= handle_r;
          odrop_r   <= !can_push;
          olast_r   <= 1'b1;
        end
        S_DSCAN: begin
          if (32'(scan_r) >= 32'(hbd_pkg::NUM_BUCKETS)) begin
            // No more buckets: either the last beat went out already
            // or nothing was found at all.
            if (!found_r) begin
              ov_r      <= 1'b1;
              okind_r   <= hbd_pkg::KIND_EMPTY;
              obkt_r    <= '0;
              ohash_r   <= '0;
              ohandle_r <= '0;
              odrop_r   <= 1'b0;
            end
            olast_r <= 1'b1;
          end else if (occ_r[sbi] == '0) begin
            scan_r <= scan_r + hbd_pkg::BCNT_W'(1);
          end else begin
            head_r[sbi] <= head_r[sbi] + hbd_pkg::QPTR_W'(1);
            occ_r[sbi]  <= occ_r[sbi] - hbd_pkg::OCC_W'(1);
          end
        end
        S_DREAD: begin
          // Last when no later bucket holds an entry.
          ov_r      <= 1'b1;
          okind_r   <= hbd_pkg::KIND_ENTRY;
          obkt_r    <= 2'(scan_r);
          ohash_r   <= ram_rdata[63:0];
          ohandle_r <= ram_rdata[95:64];
          odrop_r   <= 1'b0;
          found_r   <= 1'b1;
          scan_r    <= scan_r + hbd_pkg::BCNT_W'(1);
          olast_r   <= !later_busy;
        end
        S_OUT: begin
          if (!ov_r && olast_r && mode_r) olast_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
